// ----- rtl/fbpm_pkg.sv -----
// Shared types and codes for the frame buffer pool manager.
// No dependencies; used by every other file in rtl/.
`default_nettype none

package fbpm_pkg;

    // Fixed field widths
    localparam int CMD_W    = 3;
    localparam int FIDX_W   = 4;
    localparam int META_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FCNT_W   = 5;
    localparam int SEQ_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_GET  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DROP = 3'd4;

    // Entry ownership states
    localparam logic [1:0] ENT_FREE  = 2'd0;
    localparam logic [1:0] ENT_HELD  = 2'd1;
    localparam logic [1:0] ENT_READY = 2'd2;
    localparam logic [1:0] ENT_TX    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BUSY  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_STATE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_META  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_META = 2'd2;

    typedef struct packed {
        logic              enable;
        logic [FCNT_W-1:0] frame_count;
        logic [META_W-1:0] max_meta_count;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   grant;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/frame_buffer_pool_manager.sv -----
// Frame buffer pool manager: top level with config registers and output word.
// Depends on fbpm_pkg and fbpm_ctrl.
//
// Tracks ownership of MAX_FRAMES transmit buffers (free, held, ready,
// transmitting) under get, put, next, done and drop commands, one result
// word per command word. The block takes one command at a time and is
// stalled until its result has been loaded into the output register.
// Put, done, disabled commands and bad codes need no scan. A get scans
// the state table one entry per cycle, up to the first free entry among
// the live entries (frame_count, saturated to MAX_FRAMES). Next and drop
// walk all entries in use with the single stamp compare unit behind the
// registered stamp memory port, with an extra compare step for each ready
// entry. The state table resets to all free at once; stamp memory needs no
// clearing.
`default_nettype none

module frame_buffer_pool_manager #(
    parameter int MAX_FRAMES = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write port
    input  wire logic                               i_cfg_we,
    input  wire logic [fbpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [fbpm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // command channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [fbpm_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic [fbpm_pkg::FIDX_W-1:0]        i_frame_index,
    input  wire logic [fbpm_pkg::META_W-1:0]        i_meta_count,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [fbpm_pkg::STATUS_W-1:0]           o_status,
    output logic [fbpm_pkg::FIDX_W-1:0]             o_granted_index
);

    localparam int IW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW0 = $clog2(MAX_FRAMES + 1);
    localparam int CW  = (CW0 > fbpm_pkg::FCNT_W) ? CW0 : fbpm_pkg::FCNT_W;

    fbpm_pkg::t_cfg                  r_cfg;
    fbpm_pkg::t_result               w_res;
    logic                            w_idle;
    logic                            w_start;
    logic                            w_out_free;
    logic                            r_out_valid;
    logic [fbpm_pkg::STATUS_W-1:0]   r_out_status;
    logic [fbpm_pkg::FIDX_W-1:0]     r_out_grant;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.frame_count    <= fbpm_pkg::FCNT_W'(3);
            r_cfg.max_meta_count <= fbpm_pkg::META_W'(20);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fbpm_pkg::REG_ENABLE:    r_cfg.enable      <= i_cfg_data[0];
                fbpm_pkg::REG_FRAME_CNT: begin
                    r_cfg.frame_count <= i_cfg_data[fbpm_pkg::FCNT_W-1:0];
                end
                fbpm_pkg::REG_MAX_META:  r_cfg.max_meta_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_start    = i_in_valid && w_idle;
    assign o_in_stall = !w_idle;
    assign w_out_free = !r_out_valid || !i_out_stall;

    fbpm_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_start       (w_start),
        .i_cmd         (i_cmd),
        .i_frame_index (i_frame_index),
        .i_meta_count  (i_meta_count),
        .i_out_free    (w_out_free),
        .o_idle        (w_idle),
        .o_result      (w_res)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_out_free) begin
            r_out_status <= w_res.status;
            r_out_grant  <= w_res.grant;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = r_out_grant;

    // an accepted command keeps the input stalled in the next cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command channel not stalled after accept");

    // a pending result keeps the input stalled
    a_stall_while_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> o_in_stall)
        else $error("command taken while result pending");

    // a result handed over appears at the output next cycle
    a_result_loaded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_out_free) |=> o_out_valid)
        else $error("result word lost");

    // failed commands never carry a grant
    a_grant_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != fbpm_pkg::STS_OK) |-> (o_granted_index == '0))
        else $error("grant on failed command");

endmodule

`default_nettype wire

// ----- rtl/fbpm_seq_ram.sv -----
// Sequence stamp memory: one write port, one registered read port.
// Depends on fbpm_pkg for the stamp width.
`default_nettype none

module fbpm_seq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [fbpm_pkg::SEQ_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [fbpm_pkg::SEQ_W-1:0]  o_rdata
);

    logic [fbpm_pkg::SEQ_W-1:0] r_mem [DEPTH];
    logic [fbpm_pkg::SEQ_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/fbpm_serial_cmp.sv -----
// Shared serial-number compare: a is serially greater than b.
// One 32-bit subtractor. Depends on fbpm_pkg.
`default_nettype none

module fbpm_serial_cmp (
    input  wire logic [fbpm_pkg::SEQ_W-1:0] i_a,
    input  wire logic [fbpm_pkg::SEQ_W-1:0] i_b,
    output logic                            o_gt
);

    logic [fbpm_pkg::SEQ_W-1:0] w_diff;

    // greater when the wrapped difference is nonzero and below half range
    assign w_diff = i_a - i_b;
    assign o_gt   = (w_diff != '0) && !w_diff[fbpm_pkg::SEQ_W-1];

endmodule

`default_nettype wire

// ----- rtl/fbpm_ctrl.sv -----
// Command sequencer: entry state table, scan counter, oldest-ready search.
// Depends on fbpm_pkg, fbpm_seq_ram and fbpm_serial_cmp.
`default_nettype none

module fbpm_ctrl #(
    parameter int MAX_FRAMES = 16,
    parameter int IW         = 4,
    parameter int CW         = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fbpm_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_start,
    input  wire logic [fbpm_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [fbpm_pkg::FIDX_W-1:0]    i_frame_index,
    input  wire logic [fbpm_pkg::META_W-1:0]    i_meta_count,
    input  wire logic                           i_out_free,
    output logic                                o_idle,
    output fbpm_pkg::t_result                   o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_GET  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_PICK = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [CW-1:0] MAXF = CW'(MAX_FRAMES);
    localparam logic [CW-1:0] ONE  = CW'(1);

    logic [2:0]                      r_state, n_state;
    logic [fbpm_pkg::CMD_W-1:0]      r_cmd;
    logic [CW-1:0]                   r_fidx;
    logic [fbpm_pkg::META_W-1:0]     r_meta;
    logic [CW-1:0]                   r_n;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_best_idx, n_best_idx;
    logic [fbpm_pkg::SEQ_W-1:0]      r_best_seq, n_best_seq;
    logic                            r_have, n_have;
    logic [fbpm_pkg::SEQ_W-1:0]      r_next_seq, n_next_seq;
    logic [fbpm_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    logic [fbpm_pkg::FIDX_W-1:0]     r_res_grant, n_res_grant;
    logic [1:0]                      r_ent [MAX_FRAMES];

    logic [CW-1:0]                   w_fc;
    logic [CW-1:0]                   w_active;
    logic [CW-1:0]                   w_raddr;
    logic [1:0]                      w_ent_rd;
    logic                            w_ent_we;
    logic [CW-1:0]                   w_ent_waddr;
    logic [1:0]                      w_ent_wdata;
    logic                            w_ram_we;
    logic [fbpm_pkg::SEQ_W-1:0]      w_rdata;
    logic                            w_gt;
    logic                            w_last;
    logic                            w_fidx_ok;

    // live entry count, saturated to the pool size
    assign w_fc     = CW'(i_cfg.frame_count);
    assign w_active = (w_fc > MAXF) ? MAXF : w_fc;

    // one read address into the state table
    assign w_raddr   = (r_state == S_EXEC) ? r_fidx : r_idx;
    assign w_ent_rd  = r_ent[w_raddr[IW-1:0]];
    assign w_last    = (r_idx + ONE) == r_n;
    assign w_fidx_ok = r_fidx < r_n;

    fbpm_seq_ram #(
        .DEPTH (MAX_FRAMES),
        .AW    (IW)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (r_next_seq),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    fbpm_serial_cmp u_cmp (
        .i_a  (w_rdata),
        .i_b  (r_best_seq),
        .o_gt (w_gt)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_best_idx   = r_best_idx;
        n_best_seq   = r_best_seq;
        n_have       = r_have;
        n_next_seq   = r_next_seq;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        w_ent_we     = 1'b0;
        w_ent_waddr  = r_idx;
        w_ent_wdata  = fbpm_pkg::ENT_FREE;
        w_ram_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state      = S_EXEC;
                    n_idx        = '0;
                    n_have       = 1'b0;
                    n_res_grant  = '0;
                    n_res_status = fbpm_pkg::STS_STATE;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (r_cmd)
                    fbpm_pkg::CMD_GET: begin
                        n_res_status = fbpm_pkg::STS_BUSY;
                        if (i_cfg.enable && r_n != '0) begin
                            n_state = S_GET;
                        end
                    end
                    fbpm_pkg::CMD_NEXT, fbpm_pkg::CMD_DROP: begin
                        n_res_status = fbpm_pkg::STS_BUSY;
                        if (i_cfg.enable && r_n != '0) begin
                            n_state = S_RD;
                        end
                    end
                    fbpm_pkg::CMD_PUT: begin
                        if (!w_fidx_ok || w_ent_rd != fbpm_pkg::ENT_HELD) begin
                            n_res_status = fbpm_pkg::STS_STATE;
                        end else if (r_meta > i_cfg.max_meta_count) begin
                            n_res_status = fbpm_pkg::STS_META;
                        end else begin
                            n_res_status = fbpm_pkg::STS_OK;
                            w_ent_we     = 1'b1;
                            w_ent_waddr  = r_fidx;
                            w_ent_wdata  = fbpm_pkg::ENT_READY;
                        end
                    end
                    fbpm_pkg::CMD_DONE: begin
                        if (w_fidx_ok && w_ent_rd == fbpm_pkg::ENT_TX) begin
                            n_res_status = fbpm_pkg::STS_OK;
                            w_ent_we     = 1'b1;
                            w_ent_waddr  = r_fidx;
                            w_ent_wdata  = fbpm_pkg::ENT_FREE;
                        end else begin
                            n_res_status = fbpm_pkg::STS_STATE;
                        end
                    end
                    default: begin
                        n_res_status = fbpm_pkg::STS_STATE;
                    end
                endcase
            end
            // lowest free entry, one per cycle
            S_GET: begin
                if (w_ent_rd == fbpm_pkg::ENT_FREE) begin
                    w_ent_we     = 1'b1;
                    w_ent_wdata  = fbpm_pkg::ENT_HELD;
                    w_ram_we     = 1'b1;
                    n_next_seq   = r_next_seq + 1'b1;
                    n_res_status = fbpm_pkg::STS_OK;
                    n_res_grant  = r_idx[fbpm_pkg::FIDX_W-1:0];
                    n_state      = S_FIN;
                end else if (w_last) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            // ready check; stamp read issued at r_idx
            S_RD: begin
                if (w_ent_rd == fbpm_pkg::ENT_READY) begin
                    n_state = S_CMP;
                end else if (w_last) begin
                    n_state = S_PICK;
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            // later index wins unless its stamp is serially newer
            S_CMP: begin
                if (!r_have || !w_gt) begin
                    n_have     = 1'b1;
                    n_best_seq = w_rdata;
                    n_best_idx = r_idx;
                end
                if (w_last) begin
                    n_state = S_PICK;
                end else begin
                    n_state = S_RD;
                    n_idx   = r_idx + ONE;
                end
            end
            S_PICK: begin
                n_state = S_FIN;
                if (r_have) begin
                    w_ent_we     = 1'b1;
                    w_ent_waddr  = r_best_idx;
                    w_ent_wdata  = (r_cmd == fbpm_pkg::CMD_NEXT) ?
                                   fbpm_pkg::ENT_TX : fbpm_pkg::ENT_FREE;
                    n_res_status = fbpm_pkg::STS_OK;
                    n_res_grant  = r_best_idx[fbpm_pkg::FIDX_W-1:0];
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_next_seq <= '0;
            r_have     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_next_seq <= n_next_seq;
            r_have     <= n_have;
        end
    end

    // command word and scan datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd  <= i_cmd;
            r_fidx <= CW'(i_frame_index);
            r_meta <= i_meta_count;
            r_n    <= w_active;
        end
        r_idx        <= n_idx;
        r_best_idx   <= n_best_idx;
        r_best_seq   <= n_best_seq;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
    end

    // entry state table, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_ent[k] <= fbpm_pkg::ENT_FREE;
            end
        end else if (w_ent_we) begin
            r_ent[w_ent_waddr[IW-1:0]] <= w_ent_wdata;
        end
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_result.valid  = (r_state == S_FIN);
    assign o_result.status = r_res_status;
    assign o_result.grant  = r_res_grant;

endmodule

`default_nettype wire

// ----- verif/frame_buffer_pool_manager_checker.sv -----
// Checker for the frame buffer pool manager: tracks the pool from the command
// and config traffic, predicts every result word and compares it.
// Depends on fbpm_pkg.
`timescale 1ns / 100ps

module frame_buffer_pool_manager_checker #(
    parameter int MAX_FRAMES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [fbpm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [fbpm_pkg::FIDX_W-1:0]     i_frame_index,
    input  logic [fbpm_pkg::META_W-1:0]     i_meta_count,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [fbpm_pkg::STATUS_W-1:0]   i_status,
    input  logic [fbpm_pkg::FIDX_W-1:0]     i_granted_index,
    output int                              o_fail_count,
    output int                              o_outstanding
);

    typedef struct packed {
        logic [fbpm_pkg::CMD_W-1:0]    cmd;
        logic [fbpm_pkg::FIDX_W-1:0]   index;
        logic [fbpm_pkg::STATUS_W-1:0] status;
        logic [fbpm_pkg::FIDX_W-1:0]   grant;
    } t_pool_word;

    localparam logic [fbpm_pkg::SEQ_W-1:0]  HALF_RANGE     = 32'h8000_0000;
    localparam logic [fbpm_pkg::FCNT_W-1:0] RST_FRAMES     = 5'd3;
    localparam logic [fbpm_pkg::META_W-1:0] RST_META_LIMIT = 8'd20;

    // Pool state and register copies
    logic [1:0]                  slot_state [MAX_FRAMES];
    logic [fbpm_pkg::SEQ_W-1:0]  slot_stamp [MAX_FRAMES];
    logic [fbpm_pkg::SEQ_W-1:0]  stamp_next;
    logic                        pool_en;
    logic [fbpm_pkg::FCNT_W-1:0] pool_frames;
    logic [fbpm_pkg::META_W-1:0] meta_limit;

    // Result words still owed by the block, oldest first
    t_pool_word pending_words [$];

    int fail_total = 0;
    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("[%0t] checker: %s", $time, msg);
    endtask

    // frame_count saturates at the pool size
    function automatic int live_entries();
        return (pool_frames > MAX_FRAMES) ? MAX_FRAMES : int'(pool_frames);
    endfunction

    // Oldest ready entry by serial stamp order; the later index wins a tie.
    function automatic int oldest_ready();
        int best;
        int i;
        logic [fbpm_pkg::SEQ_W-1:0] diff;
        best = -1;
        for (i = 0; i < live_entries(); i++) begin
            if (slot_state[i] == fbpm_pkg::ENT_READY) begin
                if (best < 0) begin
                    best = i;
                end else begin
                    diff = slot_stamp[i] - slot_stamp[best];
                    if (!(diff != '0 && diff < HALF_RANGE))
                        best = i;
                end
            end
        end
        return best;
    endfunction

    // Apply one command word to the pool and return the word it should yield.
    function automatic t_pool_word pool_step(input logic [fbpm_pkg::CMD_W-1:0] c,
                                             input logic [fbpm_pkg::FIDX_W-1:0] f,
                                             input logic [fbpm_pkg::META_W-1:0] m);
        t_pool_word w;
        int n;
        int i;
        int pick;
        n = live_entries();
        w.cmd    = c;
        w.index  = f;
        w.status = fbpm_pkg::STS_STATE;
        w.grant  = '0;
        case (c)
            fbpm_pkg::CMD_GET: begin
                w.status = fbpm_pkg::STS_BUSY;
                if (pool_en) begin
                    for (i = 0; i < n; i++) begin
                        if (slot_state[i] == fbpm_pkg::ENT_FREE) begin
                            slot_state[i] = fbpm_pkg::ENT_HELD;
                            slot_stamp[i] = stamp_next;
                            stamp_next    = stamp_next + 1'b1;
                            w.status      = fbpm_pkg::STS_OK;
                            w.grant       = fbpm_pkg::FIDX_W'(i);
                            break;
                        end
                    end
                end
            end
            fbpm_pkg::CMD_PUT: begin
                if (f >= n || slot_state[f] != fbpm_pkg::ENT_HELD) begin
                    w.status = fbpm_pkg::STS_STATE;
                end else if (m > meta_limit) begin
                    w.status = fbpm_pkg::STS_META;
                end else begin
                    slot_state[f] = fbpm_pkg::ENT_READY;
                    w.status      = fbpm_pkg::STS_OK;
                end
            end
            fbpm_pkg::CMD_NEXT, fbpm_pkg::CMD_DROP: begin
                w.status = fbpm_pkg::STS_BUSY;
                if (pool_en) begin
                    pick = oldest_ready();
                    if (pick >= 0) begin
                        slot_state[pick] = (c == fbpm_pkg::CMD_NEXT) ?
                                           fbpm_pkg::ENT_TX : fbpm_pkg::ENT_FREE;
                        w.status = fbpm_pkg::STS_OK;
                        w.grant  = fbpm_pkg::FIDX_W'(pick);
                    end
                end
            end
            fbpm_pkg::CMD_DONE: begin
                if (f < n && slot_state[f] == fbpm_pkg::ENT_TX) begin
                    slot_state[f] = fbpm_pkg::ENT_FREE;
                    w.status      = fbpm_pkg::STS_OK;
                end else begin
                    w.status = fbpm_pkg::STS_STATE;
                end
            end
            default: w.status = fbpm_pkg::STS_STATE;
        endcase
        return w;
    endfunction

    // Watch both channels and the config port at every edge
    always @(posedge i_clk) begin : watch
        t_pool_word want;
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < MAX_FRAMES; i++) begin
                slot_state[i] = fbpm_pkg::ENT_FREE;
                slot_stamp[i] = '0;
            end
            stamp_next  = '0;
            pool_en     = 1'b0;
            pool_frames = RST_FRAMES;
            meta_limit  = RST_META_LIMIT;
            pending_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fbpm_pkg::REG_ENABLE:    pool_en     = i_cfg_data[0];
                    fbpm_pkg::REG_FRAME_CNT: pool_frames = i_cfg_data[fbpm_pkg::FCNT_W-1:0];
                    fbpm_pkg::REG_MAX_META:  meta_limit  = i_cfg_data[fbpm_pkg::META_W-1:0];
                    default: ;
                endcase
            end
            // result word leaving the block
            if (i_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word: status %0d grant %0d",
                                              i_status, i_granted_index));
                end else begin
                    want = pending_words.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("cmd %0d idx %0d: status %0d, want %0d",
                                                  want.cmd, want.index, i_status,
                                                  want.status));
                    if (i_granted_index !== want.grant)
                        report_mismatch($sformatf("cmd %0d idx %0d: grant %0d, want %0d",
                                                  want.cmd, want.index, i_granted_index,
                                                  want.grant));
                end
            end
            // command word entering the block
            if (i_in_valid && !i_in_stall)
                pending_words.push_back(pool_step(i_cmd, i_frame_index, i_meta_count));
        end
        o_outstanding <= pending_words.size();
    end

endmodule

// ----- verif/frame_buffer_pool_manager_tb.sv -----
// Testbench top for the frame buffer pool manager: clock, reset, config
// writes, command stimulus with random gaps and stalls, and the verdict.
// Depends on fbpm_pkg, frame_buffer_pool_manager and its checker.
`timescale 1ns / 100ps

module frame_buffer_pool_manager_tb;

    localparam int MAX_FRAMES      = 16;
    localparam int RESET_CYCLES    = 5;
    localparam int PHASES          = 14;
    localparam int WORDS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 1000000;

    // Command codes the block does not define
    localparam logic [fbpm_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [fbpm_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [fbpm_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [fbpm_pkg::CFG_IDX_W-1:0]  cfg_index     = fbpm_pkg::REG_ENABLE;
    logic [fbpm_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic [fbpm_pkg::CMD_W-1:0]      cmd           = fbpm_pkg::CMD_GET;
    logic [fbpm_pkg::FIDX_W-1:0]     frame_index   = '0;
    logic [fbpm_pkg::META_W-1:0]     meta_count    = '0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    logic [fbpm_pkg::STATUS_W-1:0]   status;
    logic [fbpm_pkg::FIDX_W-1:0]     granted_index;

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    // Receiver stall control
    int   hold_ask  = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   rx_gap    = 0;
    logic rx_quiet  = 1'b0;
    logic tx_quiet  = 1'b0;

    // Rough view of the pool used only to aim puts and dones
    logic [fbpm_pkg::CMD_W-1:0]  sent_cmds [$];
    logic [MAX_FRAMES-1:0]       held_mask      = '0;
    logic [MAX_FRAMES-1:0]       tx_mask        = '0;
    logic [fbpm_pkg::FCNT_W-1:0] cur_frames     = 5'd3;
    logic [fbpm_pkg::META_W-1:0] cur_meta_limit = 8'd20;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    frame_buffer_pool_manager #(
        .MAX_FRAMES(MAX_FRAMES)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_frame_index  (frame_index),
        .i_meta_count   (meta_count),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_granted_index(granted_index)
    );

    frame_buffer_pool_manager_checker #(
        .MAX_FRAMES(MAX_FRAMES)
    ) pool_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_frame_index  (frame_index),
        .i_meta_count   (meta_count),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_granted_index(granted_index),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    endfunction

    // Receiver: long hold-off on request, otherwise random stalls
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap    <= rx_gap - 1;
            out_stall <= 1'b1;
        end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
            rx_gap    <= idle_len() - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Follow grants so that most puts and dones hit entries in the right state
    always @(posedge clk) begin : follow_grants
        logic [fbpm_pkg::CMD_W-1:0] ret_cmd;
        if (out_valid && !out_stall && sent_cmds.size() != 0) begin
            ret_cmd = sent_cmds.pop_front();
            if (status == fbpm_pkg::STS_OK && ret_cmd == fbpm_pkg::CMD_GET)
                held_mask[granted_index] = 1'b1;
            if (status == fbpm_pkg::STS_OK && ret_cmd == fbpm_pkg::CMD_NEXT)
                tx_mask[granted_index] = 1'b1;
        end
        if (in_valid && !in_stall)
            sent_cmds.push_back(cmd);
    end

    function automatic logic [fbpm_pkg::FIDX_W-1:0] pick_from(
            input logic [MAX_FRAMES-1:0] mask);
        int start;
        int k;
        logic [fbpm_pkg::FIDX_W-1:0] slot;
        start = $urandom_range(0, MAX_FRAMES - 1);
        for (k = 0; k < MAX_FRAMES; k++) begin
            slot = fbpm_pkg::FIDX_W'((start + k) % MAX_FRAMES);
            if (mask[slot])
                return slot;
        end
        return fbpm_pkg::FIDX_W'(start);
    endfunction

    // Offer one command word and hold it until the block takes it
    task automatic send_word(input logic [fbpm_pkg::CMD_W-1:0]  c,
                             input logic [fbpm_pkg::FIDX_W-1:0] f,
                             input logic [fbpm_pkg::META_W-1:0] m);
        int gap;
        gap = (tx_quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        frame_index <= f;
        meta_count  <= m;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and wait until every result word has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on an idle block; noisy fills unused data bits
    task automatic apply_config(input logic                        en,
                                input logic [fbpm_pkg::FCNT_W-1:0] frames,
                                input logic [fbpm_pkg::META_W-1:0] limit,
                                input logic                        noisy);
        logic [fbpm_pkg::CFG_DATA_W-1:0] junk;
        junk = noisy ? fbpm_pkg::CFG_DATA_W'($urandom_range(0, 255)) : '0;
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= fbpm_pkg::REG_ENABLE;
        cfg_data  <= {junk[fbpm_pkg::CFG_DATA_W-1:1], en};
        @(posedge clk);
        cfg_index <= fbpm_pkg::REG_FRAME_CNT;
        cfg_data  <= {junk[fbpm_pkg::CFG_DATA_W-1:fbpm_pkg::FCNT_W], frames};
        @(posedge clk);
        cfg_index <= fbpm_pkg::REG_MAX_META;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_frames     = frames;
        cur_meta_limit = limit;
    endtask

    // Random command word, mostly well-formed get/put/next/done traffic
    task automatic pick_word(output logic [fbpm_pkg::CMD_W-1:0]  c,
                             output logic [fbpm_pkg::FIDX_W-1:0] f,
                             output logic [fbpm_pkg::META_W-1:0] m);
        int roll;
        int live;
        live = (cur_frames == 0) ? 1 : ((cur_frames > MAX_FRAMES) ? MAX_FRAMES : cur_frames);
        f = ($urandom_range(0, 3) == 0) ? fbpm_pkg::FIDX_W'($urandom_range(0, MAX_FRAMES - 1))
                                        : fbpm_pkg::FIDX_W'($urandom_range(0, live - 1));
        m = fbpm_pkg::META_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 24) begin
            c = fbpm_pkg::CMD_GET;
        end else if (roll < 48) begin
            c = fbpm_pkg::CMD_PUT;
            roll = $urandom_range(0, 99);
            if (roll < 75)
                m = fbpm_pkg::META_W'($urandom_range(0, cur_meta_limit));
            else if (roll < 85)
                m = roll[0] ? '1 : '0;
            if (held_mask != '0 && $urandom_range(0, 9) < 8) begin
                f = pick_from(held_mask);
                if (m <= cur_meta_limit)
                    held_mask[f] = 1'b0;
            end
        end else if (roll < 66) begin
            c = fbpm_pkg::CMD_NEXT;
        end else if (roll < 84) begin
            c = fbpm_pkg::CMD_DONE;
            if (tx_mask != '0 && $urandom_range(0, 9) < 8) begin
                f = pick_from(tx_mask);
                tx_mask[f] = 1'b0;
            end
        end else if (roll < 92) begin
            c = fbpm_pkg::CMD_DROP;
        end else if (roll < 96) begin
            c = fbpm_pkg::CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
        end else begin
            c = fbpm_pkg::CMD_W'($urandom_range(0, 7));
        end
    endtask

    initial begin : stimulus
        int ph;
        int k;
        logic [fbpm_pkg::CMD_W-1:0]  c;
        logic [fbpm_pkg::FIDX_W-1:0] f;
        logic [fbpm_pkg::META_W-1:0] m;
        logic                        en;
        logic [fbpm_pkg::FCNT_W-1:0] frames;
        logic [fbpm_pkg::META_W-1:0] limit;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Pool still disabled: get, next and drop are busy; put, done and
        // undefined codes are refused on state or index
        send_word(fbpm_pkg::CMD_GET,  4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_NEXT, 4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_DROP, 4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_PUT,  4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_DONE, 4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_PUT,  4'd15, 8'd255);
        send_word(CMD_RSVD5,          4'd15, 8'd255);
        send_word(CMD_RSVD6,          4'd0,  8'd0);
        send_word(CMD_RSVD7,          4'd15, 8'd255);

        // Three entries enabled: fill, overflow, one full buffer life cycle
        apply_config(1'b1, 5'd3, 8'd20, 1'b0);
        send_word(fbpm_pkg::CMD_GET,  4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_GET,  4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_GET,  4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_GET,  4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_PUT,  4'd0,  8'd21);   // meta count one over the limit
        send_word(fbpm_pkg::CMD_PUT,  4'd0,  8'd20);
        send_word(fbpm_pkg::CMD_PUT,  4'd1,  8'd0);
        send_word(fbpm_pkg::CMD_PUT,  4'd1,  8'd0);    // already ready
        send_word(fbpm_pkg::CMD_NEXT, 4'd0,  8'd0);    // oldest ready is entry 0
        send_word(fbpm_pkg::CMD_DONE, 4'd1,  8'd0);    // ready, not transmitting
        send_word(fbpm_pkg::CMD_DONE, 4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_DROP, 4'd0,  8'd0);
        send_word(fbpm_pkg::CMD_PUT,  4'd3,  8'd0);    // beyond frame_count
        send_word(fbpm_pkg::CMD_DONE, 4'd15, 8'd255);
        send_word(fbpm_pkg::CMD_NEXT, 4'd0,  8'd0);    // nothing ready

        // Random phases, first through the register extremes
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin en = 1'b1; frames = 5'd16; limit = 8'd255; end
                1: begin en = 1'b1; frames = 5'd1;  limit = 8'd0;   end
                2: begin en = 1'b1; frames = 5'd0;  limit = 8'd20;  end
                3: begin en = 1'b1; frames = 5'd31; limit = 8'd100; end
                4: begin en = 1'b0; frames = 5'd5;  limit = 8'd50;  end
                5: begin en = 1'b1; frames = 5'd17; limit = 8'd255; end
                6: begin en = 1'b1; frames = 5'd4;  limit = 8'd20;  end
                default: begin
                    en     = ($urandom_range(0, 7) != 0);
                    frames = ($urandom_range(0, 3) == 0) ?
                             fbpm_pkg::FCNT_W'($urandom_range(0, 31)) :
                             fbpm_pkg::FCNT_W'($urandom_range(2, 8));
                    limit  = fbpm_pkg::META_W'($urandom_range(0, 255));
                end
            endcase
            apply_config(en, frames, limit, ph >= 7);
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet <= ($urandom_range(0, 4) == 0);
            // receiver holds off while the sender keeps offering
            if (ph == 3 || ph == 10)
                hold_ask <= hold_ask + 1;
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                pick_word(c, f, m);
                send_word(c, f, m);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- frame_buffer_pool_manager.f -----
rtl/fbpm_pkg.sv
rtl/fbpm_seq_ram.sv
rtl/fbpm_serial_cmp.sv
rtl/fbpm_ctrl.sv
rtl/frame_buffer_pool_manager.sv
verif/frame_buffer_pool_manager_checker.sv
verif/frame_buffer_pool_manager_tb.sv
